>>> hw/rtl/gri_pkg.sv
// ----------------------------------------------------------------------------
// gri_pkg: shared definitions for the GSPH Riemann interface setup
// Data type, saturation limits, saturating helpers and unit latencies.
// ----------------------------------------------------------------------------
package gri_pkg;

	localparam int DATA_W        = 48;
	localparam int MAX_EQ        = 3;
	localparam int NUM_EQ_DEF    = 3;
	localparam int FRAC_BITS_DEF = 24;
	localparam int MUL_LAT       = 4;

	typedef logic signed [DATA_W-1:0] dat_t;

	localparam logic [DATA_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] MAG_MIN = 48'h8000_0000_0000;

	typedef struct packed {
		logic neg;
		logic a_neg;
		logic b_zero;
		logic a_zero;
	} div_flags_t;

	// Latency of the divider: magnitude stage, one stage per quotient bit, result stage.
	function automatic int div_lat(input int frac_bits);
		return DATA_W + frac_bits + 2;
	endfunction

	function automatic dat_t sat_add(input dat_t a, input dat_t b);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? dat_t'(MAG_MIN) : dat_t'(POS_MAX);
		return s[DATA_W-1:0];
	endfunction

	function automatic dat_t sat_sub(input dat_t a, input dat_t b);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? dat_t'(MAG_MIN) : dat_t'(POS_MAX);
		return s[DATA_W-1:0];
	endfunction

	// Halving truncated toward zero: a negative value is bumped by one first.
	function automatic dat_t halve(input dat_t x);
		dat_t t;
		t = x + dat_t'({{(DATA_W-1){1'b0}}, x[DATA_W-1]});
		return t >>> 1;
	endfunction

endpackage

>>> hw/rtl/gri_delay.sv
// ----------------------------------------------------------------------------
// gri_delay: stalling delay line
// Holds each value in a shift register that advances only while en is set, to line it up with other operands.
// ----------------------------------------------------------------------------
module gri_delay #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sh_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	assign q = sh_q[DEPTH-1];

endmodule

>>> hw/rtl/gri_mul.sv
// ----------------------------------------------------------------------------
// gri_mul: pipelined saturating fixed-point multiplier
// Sign-magnitude product from four 24x24 partial products, truncated and clamped.
// ----------------------------------------------------------------------------
module gri_mul #(
	parameter int FRAC_BITS = gri_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  gri_pkg::dat_t a,
	input  gri_pkg::dat_t b,
	output gri_pkg::dat_t p
);

	localparam int DW = gri_pkg::DATA_W;
	localparam int HW = DW / 2;
	localparam int PW = 2 * DW;

	logic [DW-1:0] am_s1, bm_s1;
	logic          neg_s1, neg_s2, neg_s3;
	logic [DW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic [PW-1:0] prod_s3;
	logic [PW-1:0] shr;
	gri_pkg::dat_t p_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1   <= a[DW-1] ? DW'(-a) : DW'(a);
			bm_s1   <= b[DW-1] ? DW'(-b) : DW'(b);
			neg_s1  <= a[DW-1] ^ b[DW-1];
			p0_s2   <= am_s1[HW-1:0] * bm_s1[HW-1:0];
			p1_s2   <= am_s1[HW-1:0] * bm_s1[DW-1:HW];
			p2_s2   <= am_s1[DW-1:HW] * bm_s1[HW-1:0];
			p3_s2   <= am_s1[DW-1:HW] * bm_s1[DW-1:HW];
			neg_s2  <= neg_s1;
			prod_s3 <= PW'(p0_s2) + ((PW'(p1_s2) + PW'(p2_s2)) << HW) + (PW'(p3_s2) << DW);
			neg_s3  <= neg_s2;
			p_s4    <= (neg_s3 ? ((shr >= PW'(gri_pkg::MAG_MIN)) ? gri_pkg::dat_t'(gri_pkg::MAG_MIN)
			                                            : gri_pkg::dat_t'(-shr[DW-1:0]))
			                   : ((shr > PW'(gri_pkg::POS_MAX)) ? gri_pkg::dat_t'(gri_pkg::POS_MAX)
			                                           : gri_pkg::dat_t'(shr[DW-1:0])));
		end
	end

	assign shr = prod_s3 >> FRAC_BITS;
	assign p   = p_s4;

endmodule

>>> hw/rtl/gri_div.sv
// ----------------------------------------------------------------------------
// gri_div: pipelined saturating fixed-point divider
// Restoring division, one quotient bit per stage, with zero-divisor handling.
// ----------------------------------------------------------------------------
module gri_div #(
	parameter int FRAC_BITS = gri_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  gri_pkg::dat_t num,
	input  gri_pkg::dat_t den,
	output gri_pkg::dat_t quo
);

	localparam int DW = gri_pkg::DATA_W;
	localparam int NB = DW + FRAC_BITS;
	localparam int RW = DW + 1;

	logic [RW-1:0]       rem_s [0:NB];
	logic [NB-1:0]       nm_s  [0:NB];
	logic [NB-1:0]       q_s   [0:NB];
	logic [DW-1:0]       bm_s  [0:NB];
	gri_pkg::div_flags_t fl_s  [0:NB];
	gri_pkg::dat_t       quo_q;
	logic [NB-1:0]       qf;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]        <= '0;
			nm_s[0]         <= {(num[DW-1] ? DW'(-num) : DW'(num)), {FRAC_BITS{1'b0}}};
			q_s[0]          <= '0;
			bm_s[0]         <= den[DW-1] ? DW'(-den) : DW'(den);
			fl_s[0].neg     <= num[DW-1] ^ den[DW-1];
			fl_s[0].a_neg   <= num[DW-1];
			fl_s[0].b_zero  <= (den == '0);
			fl_s[0].a_zero  <= (num == '0);
		end
	end

	for (genvar i = 0; i < NB; i++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = {rem_s[i][RW-2:0], nm_s[i][NB-1]};
		assign ge    = (trial >= RW'(bm_s[i]));
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? (trial - RW'(bm_s[i])) : trial;
				nm_s[i+1]  <= nm_s[i] << 1;
				q_s[i+1]   <= {q_s[i][NB-2:0], ge};
				bm_s[i+1]  <= bm_s[i];
				fl_s[i+1]  <= fl_s[i];
			end
		end
	end

	assign qf = q_s[NB];

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_s[NB].b_zero) begin
				if (fl_s[NB].a_zero) begin
					quo_q <= '0;
				end else begin
					quo_q <= fl_s[NB].a_neg ? gri_pkg::dat_t'(gri_pkg::MAG_MIN)
					                       : gri_pkg::dat_t'(gri_pkg::POS_MAX);
				end
			end else if (fl_s[NB].neg) begin
				quo_q <= (qf >= NB'(gri_pkg::MAG_MIN)) ? gri_pkg::dat_t'(gri_pkg::MAG_MIN)
				                                      : gri_pkg::dat_t'(-qf[DW-1:0]);
			end else begin
				quo_q <= (qf > NB'(gri_pkg::POS_MAX)) ? gri_pkg::dat_t'(gri_pkg::POS_MAX)
				                                     : gri_pkg::dat_t'(qf[DW-1:0]);
			end
		end
	end

	assign quo = quo_q;

endmodule

>>> hw/rtl/gri_lane.sv
// ----------------------------------------------------------------------------
// gri_lane: extrapolation lane for one state component
// Forms the component gradient and both extrapolated Riemann states.
// ----------------------------------------------------------------------------
module gri_lane #(
	parameter int FRAC_BITS = gri_pkg::FRAC_BITS_DEF,
	parameter int G_DEPTH   = 1,
	parameter int U_DEPTH   = 1
) (
	input  logic          clk,
	input  logic          en,
	input  gri_pkg::dat_t ui,
	input  gri_pkg::dat_t uj,
	input  gri_pkg::dat_t pair_dist,
	input  gri_pkg::dat_t dsi,
	input  gri_pkg::dat_t dsj,
	output gri_pkg::dat_t right,
	output gri_pkg::dat_t left
);

	gri_pkg::dat_t diff_s1, dist_s1, grad, grad_d, pr, pl, ui_d, uj_d, right_q, left_q;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= gri_pkg::sat_sub(ui, uj);
			dist_s1 <= pair_dist;
		end
	end

	gri_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .en(en), .num(diff_s1), .den(dist_s1), .quo(grad)
	);

	gri_delay #(.WIDTH(gri_pkg::DATA_W), .DEPTH(G_DEPTH)) u_dg (
		.clk(clk), .en(en), .d(grad), .q(grad_d)
	);
	gri_delay #(.WIDTH(gri_pkg::DATA_W), .DEPTH(U_DEPTH)) u_dui (
		.clk(clk), .en(en), .d(ui), .q(ui_d)
	);
	gri_delay #(.WIDTH(gri_pkg::DATA_W), .DEPTH(U_DEPTH)) u_duj (
		.clk(clk), .en(en), .d(uj), .q(uj_d)
	);

	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mr (.clk(clk), .en(en), .a(grad_d), .b(dsi), .p(pr));
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_ml (.clk(clk), .en(en), .a(grad_d), .b(dsj), .p(pl));

	always_ff @(posedge clk) begin
		if (en) begin
			right_q <= gri_pkg::sat_add(ui_d, pr);
			left_q  <= gri_pkg::sat_add(uj_d, pl);
		end
	end

	assign right = right_q;
	assign left  = left_q;

endmodule

>>> hw/rtl/gsph_riemann_interface_setup.sv
// ----------------------------------------------------------------------------
// gsph_riemann_interface_setup: GSPH Riemann interface setup for a pair
// Interface point, characteristic offsets and linearly extrapolated states.
// ----------------------------------------------------------------------------
// The block accepts one particle pair per clock while the output register
// can hand over its beat, and returns one beat holding the right and left
// Riemann states for each pair, in order. It is a fully pipelined datapath
// with no state carried between pairs. The pipeline depth is set by three
// dividers in series (specific volume, volume gradient and interface point),
// each resolving one quotient bit per stage, plus the multipliers in series
// of four stages each. The whole pipeline advances while the output register
// is empty or being taken, so a stalled downstream holds every pair in place
// and a new beat is taken in the same cycle the result is taken. The time
// step register is meant to be written while no pair is in flight; it feeds
// the first multiplier stage directly.
module gsph_riemann_interface_setup #(
	parameter int NUM_EQUATIONS = gri_pkg::NUM_EQ_DEF,
	parameter int FRAC_BITS     = gri_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         time_step_we,
	input  logic [46:0]  time_step_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_density, first_comp_one, first_comp_two, second_density,
	// second_comp_one, second_comp_two, pair_distance, smoothing_length,
	// sound_speed_first, sound_speed_second, then zero padding
	input  logic [479:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// right_comp_zero, right_comp_one, right_comp_two,
	// left_comp_zero, left_comp_one, left_comp_two
	output logic [287:0] m_tdata
);

	localparam int DW = gri_pkg::DATA_W;
	localparam int LD = gri_pkg::div_lat(FRAC_BITS);
	localparam int LM = gri_pkg::MUL_LAT;
	// Cycle at which the volume gradient is ready, then the interface point.
	localparam int TC = 2 * LD + 1;
	localparam int TS = TC + 2 * LM + 3 + LD;
	localparam int LAT = TS + 3 + LM;

	logic [46:0] time_step_q;
	logic [LAT:1] vld_q;
	logic en;

	gri_pkg::dat_t ui [0:gri_pkg::MAX_EQ-1];
	gri_pkg::dat_t uj [0:gri_pkg::MAX_EQ-1];
	gri_pkg::dat_t right [0:gri_pkg::MAX_EQ-1];
	gri_pkg::dat_t left  [0:gri_pkg::MAX_EQ-1];
	gri_pkg::dat_t pair_dist, h, ci, cj, dt, one, hd;

	gri_pkg::dat_t vi, vj, vd_s1, dm_s1, hh, hh_d, dist_d, cg, dmdm, dmdm_d, dm_d, h_d;
	gri_pkg::dat_t hc, t_s1, hhc, num, num_d, tt, var_s1, var2_s1, sstar;
	gri_pkg::dat_t cidt, cjdt, hci_s1, hcj_s1, hci_d, hcj_d, hd_d;
	gri_pkg::dat_t s1_s1, s2_s1, dsi_s1, dsj_s1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
		end else if (time_step_we) begin
			time_step_q <= time_step_wdata;
		end
	end

	// The pipeline moves whenever the output register can hand over its beat.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], s_tvalid};
		end
	end

	// Unpack the input beat; unsigned fields are zero extended.
	assign ui[0]     = {1'b0, s_tdata[46:0]};
	assign ui[1]     = s_tdata[94:47];
	assign ui[2]     = s_tdata[142:95];
	assign uj[0]     = {1'b0, s_tdata[189:143]};
	assign uj[1]     = s_tdata[237:190];
	assign uj[2]     = s_tdata[285:238];
	assign pair_dist = {1'b0, s_tdata[332:286]};
	assign h         = {1'b0, s_tdata[379:333]};
	assign ci        = {1'b0, s_tdata[426:380]};
	assign cj        = {1'b0, s_tdata[473:427]};
	assign dt        = {1'b0, time_step_q};
	assign one       = gri_pkg::dat_t'(1) << FRAC_BITS;
	// The distance is never negative, so halving it is a plain shift.
	assign hd        = pair_dist >>> 1;

	// Specific volumes of both particles.
	gri_div #(.FRAC_BITS(FRAC_BITS)) u_div_vi (
		.clk(clk), .en(en), .num(one), .den(ui[0]), .quo(vi)
	);
	gri_div #(.FRAC_BITS(FRAC_BITS)) u_div_vj (
		.clk(clk), .en(en), .num(one), .den(uj[0]), .quo(vj)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			vd_s1 <= gri_pkg::sat_sub(vi, vj);
			dm_s1 <= gri_pkg::halve(gri_pkg::sat_add(vi, vj));
		end
	end

	gri_delay #(.WIDTH(DW), .DEPTH(LD + 1)) u_d_dist (
		.clk(clk), .en(en), .d(pair_dist), .q(dist_d)
	);

	// Volume gradient along the pair.
	gri_div #(.FRAC_BITS(FRAC_BITS)) u_div_cg (
		.clk(clk), .en(en), .num(vd_s1), .den(dist_d), .quo(cg)
	);

	// h*h is formed early and waits for the gradient.
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hh (.clk(clk), .en(en), .a(h), .b(h), .p(hh));
	gri_delay #(.WIDTH(DW), .DEPTH(TC - LM)) u_d_hh (
		.clk(clk), .en(en), .d(hh), .q(hh_d)
	);
	gri_delay #(.WIDTH(DW), .DEPTH(TC)) u_d_h (
		.clk(clk), .en(en), .d(h), .q(h_d)
	);

	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dd (
		.clk(clk), .en(en), .a(dm_s1), .b(dm_s1), .p(dmdm)
	);
	gri_delay #(.WIDTH(DW), .DEPTH(LD + LM + 1)) u_d_dmdm (
		.clk(clk), .en(en), .d(dmdm), .q(dmdm_d)
	);
	gri_delay #(.WIDTH(DW), .DEPTH(LD + LM)) u_d_dm (
		.clk(clk), .en(en), .d(dm_s1), .q(dm_d)
	);

	// Variance term and the numerator ((h*h)*C)*D.
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hc (.clk(clk), .en(en), .a(h_d), .b(cg), .p(hc));
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hhc (.clk(clk), .en(en), .a(hh_d), .b(cg), .p(hhc));
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_num (.clk(clk), .en(en), .a(hhc), .b(dm_d), .p(num));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= gri_pkg::halve(hc);
		end
	end

	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_tt (.clk(clk), .en(en), .a(t_s1), .b(t_s1), .p(tt));

	always_ff @(posedge clk) begin
		if (en) begin
			var_s1  <= gri_pkg::sat_add(tt, dmdm_d);
			var2_s1 <= gri_pkg::sat_add(var_s1, var_s1);
		end
	end

	gri_delay #(.WIDTH(DW), .DEPTH(3)) u_d_num (
		.clk(clk), .en(en), .d(num), .q(num_d)
	);

	// Interface point s*.
	gri_div #(.FRAC_BITS(FRAC_BITS)) u_div_ss (
		.clk(clk), .en(en), .num(num_d), .den(var2_s1), .quo(sstar)
	);

	// Sound-speed offsets, formed at the start and held until s* arrives.
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ci (.clk(clk), .en(en), .a(ci), .b(dt), .p(cidt));
	gri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_cj (.clk(clk), .en(en), .a(cj), .b(dt), .p(cjdt));

	always_ff @(posedge clk) begin
		if (en) begin
			hci_s1 <= gri_pkg::halve(cidt);
			hcj_s1 <= gri_pkg::halve(cjdt);
		end
	end

	gri_delay #(.WIDTH(DW), .DEPTH(TS - LM - 1)) u_d_hci (
		.clk(clk), .en(en), .d(hci_s1), .q(hci_d)
	);
	gri_delay #(.WIDTH(DW), .DEPTH(TS - LM - 1)) u_d_hcj (
		.clk(clk), .en(en), .d(hcj_s1), .q(hcj_d)
	);
	gri_delay #(.WIDTH(DW), .DEPTH(TS + 1)) u_d_hd (
		.clk(clk), .en(en), .d(hd), .q(hd_d)
	);

	// Characteristic offsets dsi and dsj.
	always_ff @(posedge clk) begin
		if (en) begin
			s1_s1  <= gri_pkg::sat_add(sstar, hci_d);
			s2_s1  <= gri_pkg::sat_sub(sstar, hcj_d);
			dsi_s1 <= gri_pkg::sat_sub(s1_s1, hd_d);
			dsj_s1 <= gri_pkg::sat_add(s2_s1, hd_d);
		end
	end

	// One lane per state component; unused components read as zero.
	for (genvar c = 0; c < gri_pkg::MAX_EQ; c++) begin : g_lane
		if (c < NUM_EQUATIONS) begin : g_on
			gri_lane #(
				.FRAC_BITS(FRAC_BITS),
				.G_DEPTH  (TS + 1 - LD),
				.U_DEPTH  (TS + 2 + LM)
			) u_lane (
				.clk      (clk),
				.en       (en),
				.ui       (ui[c]),
				.uj       (uj[c]),
				.pair_dist(pair_dist),
				.dsi      (dsi_s1),
				.dsj      (dsj_s1),
				.right    (right[c]),
				.left     (left[c])
			);
		end else begin : g_off
			assign right[c] = '0;
			assign left[c]  = '0;
		end
	end

	assign m_tdata = {left[2], left[1], left[0], right[2], right[1], right[0]};

	// An accepted beat enters the first valid stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[1])
		else $error("accepted beat did not enter the pipeline");

	// A stalled pipeline keeps every beat in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	// Input readiness follows the state of the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output register");

endmodule

>>> verif/tb_gsph_riemann_interface_setup.sv
// ----------------------------------------------------------------------------
// tb_gsph_riemann_interface_setup: self-checking bench for the Riemann setup
// Streams particle pairs through the block with random source gaps and sink
// stalls. A scoreboard computes the expected right and left states for each
// accepted pair in saturating Q23.24 and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_gsph_riemann_interface_setup;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC      = gri_pkg::FRAC_BITS_DEF;
	// Pipeline latency given for the block plus some margin.
	localparam int SETTLE    = 3 * (50 + FRAC) + 3 * 4 + 7 + 60;
	localparam int IDLE_MAX  = 4000;
	localparam int N_RANDOM  = 1430;
	localparam longint SMAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SMIN  = -64'sh0000_8000_0000_0000;
	localparam logic [46:0] U47MAX = 47'h7FFF_FFFF_FFFF;
	localparam logic [46:0] ONE_Q  = 47'd1 << FRAC;

	// Pair beat on s_tdata, first field in the lowest bits.
	typedef struct packed {
		logic [5:0]    pad;
		logic [46:0]   speed_j;
		logic [46:0]   speed_i;
		logic [46:0]   hlen;
		logic [46:0]   pair_dist;
		gri_pkg::dat_t uj2;
		gri_pkg::dat_t uj1;
		logic [46:0]   rho_j;
		gri_pkg::dat_t ui2;
		gri_pkg::dat_t ui1;
		logic [46:0]   rho_i;
	} pair_t;

	// Result beat on m_tdata: right state in the low half, left above it.
	typedef struct packed {
		gri_pkg::dat_t l2, l1, l0, r2, r1, r0;
	} states_t;

	class riemann_scoreboard;
		states_t     pending[$];
		logic [46:0] dt;
		int          errors;
		int          checked;

		function longint sat(longint x);
			if (x > SMAX) return SMAX;
			if (x < SMIN) return SMIN;
			return x;
		endfunction

		function longint from_mag(bit neg, logic [63:0] m);
			if (neg) return (m >= 64'h8000_0000_0000) ? SMIN : -longint'(m);
			return (m > 64'h7FFF_FFFF_FFFF) ? SMAX : longint'(m);
		endfunction

		function logic [63:0] mag(longint x);
			return (x < 0) ? -x : x;
		endfunction

		function longint half(longint x);
			return from_mag(x < 0, mag(x) >> 1);
		endfunction

		// Exact product, truncated toward zero, then saturated.
		function longint qmul(longint a, longint b);
			logic [95:0] p;
			logic [71:0] r;
			p = mag(a) * mag(b);
			r = p[95:FRAC];
			if (r > 72'h8000_0000_0000) r = 72'h8000_0000_0001;
			return from_mag((a < 0) != (b < 0), r[63:0]);
		endfunction

		// Exact quotient; a zero divisor saturates with the dividend's sign, and zero over zero gives zero.
		function longint qdiv(longint a, longint b);
			logic [71:0] n, q;
			logic [63:0] am;
			if (b == 0) begin
				if (a == 0) return 0;
				return (a < 0) ? SMIN : SMAX;
			end
			am = mag(a);
			n = {am[47:0], 24'b0} >> (24 - FRAC);
			q = n / {8'b0, mag(b)};
			if (q > 72'h8000_0000_0000) q = 72'h8000_0000_0001;
			return from_mag((a < 0) != (b < 0), q[63:0]);
		endfunction

		function states_t riemann_states(pair_t p);
			longint ui[3], uj[3], res_r[3], res_l[3];
			longint pair_dist, h, vi, vj, cg, dm, t, vv, num, sstar, dsi, dsj, g;
			states_t s;
			ui[0] = longint'(p.rho_i); ui[1] = longint'(p.ui1); ui[2] = longint'(p.ui2);
			uj[0] = longint'(p.rho_j); uj[1] = longint'(p.uj1); uj[2] = longint'(p.uj2);
			pair_dist = longint'(p.pair_dist);
			h     = longint'(p.hlen);
			vi    = qdiv(longint'(ONE_Q), ui[0]);
			vj    = qdiv(longint'(ONE_Q), uj[0]);
			cg    = qdiv(sat(vi - vj), pair_dist);
			dm    = half(sat(vi + vj));
			t     = half(qmul(h, cg));
			vv    = sat(qmul(t, t) + qmul(dm, dm));
			num   = qmul(qmul(qmul(h, h), cg), dm);
			sstar = qdiv(num, sat(vv + vv));
			dsi   = sat(sat(sstar + half(qmul(longint'(p.speed_i), longint'(dt))))
				- half(pair_dist));
			dsj   = sat(sat(sstar - half(qmul(longint'(p.speed_j), longint'(dt))))
				+ half(pair_dist));
			for (int c = 0; c < gri_pkg::MAX_EQ; c++) begin
				res_r[c] = 0;
				res_l[c] = 0;
				if (c < gri_pkg::NUM_EQ_DEF) begin
					g = qdiv(sat(ui[c] - uj[c]), pair_dist);
					res_r[c] = sat(ui[c] + qmul(g, dsi));
					res_l[c] = sat(uj[c] + qmul(g, dsj));
				end
			end
			s.r0 = gri_pkg::dat_t'(res_r[0]);
			s.r1 = gri_pkg::dat_t'(res_r[1]);
			s.r2 = gri_pkg::dat_t'(res_r[2]);
			s.l0 = gri_pkg::dat_t'(res_l[0]);
			s.l1 = gri_pkg::dat_t'(res_l[1]);
			s.l2 = gri_pkg::dat_t'(res_l[2]);
			return s;
		endfunction

		function void note_pair(pair_t p);
			pending.push_back(riemann_states(p));
		endfunction

		task report(string what, gri_pkg::dat_t got, gri_pkg::dat_t want);
			$display("  mismatch %s on result %0d: got %h expected %h",
				what, checked, got, want);
			errors++;
		endtask

		task check_states(states_t got);
			states_t want;
			if (pending.size() == 0) begin
				$display("  unexpected result beat %0d: %h", checked, got);
				errors++;
				checked++;
				return;
			end
			want = pending.pop_front();
			if (got.r0 !== want.r0) report("right_comp_zero", got.r0, want.r0);
			if (got.r1 !== want.r1) report("right_comp_one", got.r1, want.r1);
			if (got.r2 !== want.r2) report("right_comp_two", got.r2, want.r2);
			if (got.l0 !== want.l0) report("left_comp_zero", got.l0, want.l0);
			if (got.l1 !== want.l1) report("left_comp_one", got.l1, want.l1);
			if (got.l2 !== want.l2) report("left_comp_two", got.l2, want.l2);
			checked++;
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         time_step_we = 1'b0;
	logic [46:0]  time_step_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [479:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [287:0] m_tdata;

	riemann_scoreboard sb = new();
	bit  calm;        // when set, neither side idles
	int  stall_left = 0;
	int  idle_cycles = 0;
	int  pairs_sent;

	gsph_riemann_interface_setup dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.time_step_we    (time_step_we),
		.time_step_wdata (time_step_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

	always #2 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The sink stalls in bursts drawn from the same distribution.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			m_tready <= 1'b1;
		end
	end

	// Result monitor: every accepted beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_states(states_t'(m_tdata));
	end

	// Watchdog on cycles where neither side moves a beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("timeout with %0d results outstanding", sb.pending.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [46:0] rnd47();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[46:0];
	endfunction

	function automatic gri_pkg::dat_t rnd48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	// Physically plausible pair: densities near 1, modest distances and speeds.
	function automatic pair_t plausible_pair();
		pair_t p;
		p = '0;
		p.rho_i     = 47'($urandom_range(1 << 22, 1 << 27));
		p.rho_j     = 47'($urandom_range(1 << 22, 1 << 27));
		p.ui1       = gri_pkg::dat_t'($signed($urandom_range(0, 32'h7FFF_FFFF))
			- 32'sh4000_0000);
		p.ui2       = gri_pkg::dat_t'($signed($urandom_range(0, 32'h7FFF_FFFF))
			- 32'sh4000_0000);
		p.uj1       = gri_pkg::dat_t'($signed($urandom_range(0, 32'h7FFF_FFFF))
			- 32'sh4000_0000);
		p.uj2       = gri_pkg::dat_t'($signed($urandom_range(0, 32'h7FFF_FFFF))
			- 32'sh4000_0000);
		p.pair_dist = 47'($urandom_range(1 << 18, 1 << 26));
		p.hlen      = 47'($urandom_range(1 << 20, 1 << 26));
		p.speed_i   = 47'($urandom_range(0, 1 << 27));
		p.speed_j   = 47'($urandom_range(0, 1 << 27));
		return p;
	endfunction

	// Raw pair: every bit of every field but the padding is random, with the fields that must be nonzero kept legal.
	function automatic pair_t raw_pair();
		pair_t p;
		p = '0;
		p.rho_i = rnd47(); p.rho_j = rnd47(); p.pair_dist = rnd47();
		p.ui1 = rnd48(); p.ui2 = rnd48(); p.uj1 = rnd48(); p.uj2 = rnd48();
		p.hlen = rnd47(); p.speed_i = rnd47(); p.speed_j = rnd47();
		if (p.rho_i == '0) p.rho_i = 47'd1;
		if (p.rho_j == '0) p.rho_j = 47'd1;
		if (p.pair_dist == '0) p.pair_dist = 47'd1;
		return p;
	endfunction

	// Sends one pair after a random gap and waits for the handshake.
	task automatic send_pair(pair_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pair(p);
		pairs_sent++;
	endtask

	// Holds the source until all predicted results have come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// The time step is only changed while the pipeline is empty.
	task automatic set_time_step(logic [46:0] v);
		drain();
		time_step_we    <= 1'b1;
		time_step_wdata <= v;
		@(posedge clk);
		time_step_we <= 1'b0;
		sb.dt = v;
	endtask

	task automatic random_phase(int count);
		pair_t p;
		for (int i = 0; i < count; i++) begin
			p = ($urandom_range(0, 99) < 70) ? plausible_pair() : raw_pair();
			send_pair(p);
		end
	endtask

	initial begin
		pair_t p;
		sb.dt = '0;
		sb.errors = 0;
		sb.checked = 0;
		pairs_sent = 0;
		calm = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_time_step(ONE_Q >> 4);

		// Directed pairs at the edges of the number range, sent back to back.
		p = plausible_pair();
		send_pair(p);
		p.rho_i = 47'd1; p.rho_j = 47'd1;         // equal tiny densities: volumes saturate
		send_pair(p);
		p.rho_i = 47'd1; p.rho_j = U47MAX;        // extreme density contrast
		send_pair(p);
		p.rho_i = U47MAX; p.rho_j = U47MAX;       // huge densities, tiny volumes
		send_pair(p);
		p = plausible_pair(); p.pair_dist = 47'd1;    // minimum distance, gradients saturate
		send_pair(p);
		p = plausible_pair(); p.pair_dist = U47MAX;   // maximum distance
		send_pair(p);
		p = plausible_pair(); p.hlen = '0;         // zero smoothing length
		send_pair(p);
		p = plausible_pair(); p.hlen = U47MAX;     // products overflow and clip
		send_pair(p);
		p = plausible_pair(); p.speed_i = '0; p.speed_j = '0;
		send_pair(p);
		p = plausible_pair(); p.speed_i = U47MAX; p.speed_j = U47MAX;
		send_pair(p);
		p = plausible_pair();
		p.ui1 = gri_pkg::dat_t'(gri_pkg::MAG_MIN); p.uj1 = gri_pkg::dat_t'(gri_pkg::POS_MAX);
		p.ui2 = gri_pkg::dat_t'(gri_pkg::POS_MAX); p.uj2 = gri_pkg::dat_t'(gri_pkg::MAG_MIN);
		send_pair(p);
		p = plausible_pair(); p.rho_j = p.rho_i;   // equal densities, zero gradient
		p.uj1 = p.ui1; p.uj2 = p.ui2;
		send_pair(p);
		p = '1; p.pad = '0;
		send_pair(p);
		p = '0; p.rho_i = 47'd1; p.rho_j = 47'd1; p.pair_dist = 47'd1;
		send_pair(p);

		// Random phases under changing time steps, with both sides idling.
		calm = 1'b0;
		set_time_step('0);
		random_phase(300);
		set_time_step(U47MAX);
		random_phase(250);
		// A stretch with no idling on either side.
		calm = 1'b1;
		set_time_step(47'd1);
		random_phase(200);
		calm = 1'b0;
		set_time_step(ONE_Q / 100);
		random_phase(200);
		drain();                                   // let the pipeline run empty mid-phase
		random_phase(200);
		set_time_step(rnd47());
		random_phase(N_RANDOM - 1150);

		drain();
		$display("Covered %0d pairs and %0d result beats over six time step settings,",
			pairs_sent, sb.checked);
		$display("with saturating extremes, zero smoothing length and random stalls.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/gri_pkg.sv
hw/rtl/gri_delay.sv
hw/rtl/gri_mul.sv
hw/rtl/gri_div.sv
hw/rtl/gri_lane.sv
hw/rtl/gsph_riemann_interface_setup.sv
verif/tb_gsph_riemann_interface_setup.sv
